/* design/hgcm_pkg.sv */
// Shared types, constants and codes for the height gradient colour mapper.
// Used by every module of the block; depends on nothing else.
package hgcm_pkg;

    // Field widths
    localparam int HEIGHT_BITS = 16;
    localparam int CHAN_BITS   = 8;
    localparam int COLOR_BITS  = 3 * CHAN_BITS;

    // Stream packing: height, has_color and own_color in tdata, kind and first in tuser
    localparam int IN_FIELD_BITS = HEIGHT_BITS + 1 + COLOR_BITS;
    localparam int IN_DATA_BITS  = ((IN_FIELD_BITS + 7) / 8) * 8;
    localparam int IN_USER_BITS  = 2;
    localparam int OUT_DATA_BITS = ((COLOR_BITS + 7) / 8) * 8;

    // Arithmetic widths of the shared unit
    localparam int MUL_A_BITS = CHAN_BITS + 1;
    localparam int MUL_B_BITS = HEIGHT_BITS + 1;
    localparam int PROD_BITS  = MUL_A_BITS + MUL_B_BITS;
    localparam int NUM_BITS   = PROD_BITS + 1;
    localparam int STEP_BITS  = $clog2(CHAN_BITS);

    // Configuration registers
    localparam int CFG_INDEX_BITS = 1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_LOW_COLOR  = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_HIGH_COLOR = 1'b1;
    localparam logic [COLOR_BITS-1:0] LOW_COLOR_RESET  = '0;
    localparam logic [COLOR_BITS-1:0] HIGH_COLOR_RESET = '1;

    // Item kinds
    localparam logic KIND_SCAN  = 1'b0;
    localparam logic KIND_COLOR = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL_LO,
        S_MUL_SPAN,
        S_ACC,
        S_DIV,
        S_DONE
    } seq_state_t;

    typedef enum logic [2:0] {
        OP_IDLE,
        OP_LOAD,
        OP_OWN,
        OP_MUL_LO,
        OP_MUL_SPAN,
        OP_ACC,
        OP_DIV
    } dp_op_t;

    typedef enum logic [1:0] {
        CH_BLUE  = 2'd0,
        CH_GREEN = 2'd1,
        CH_RED   = 2'd2
    } chan_t;

    typedef struct packed {
        dp_op_t                op;
        chan_t                 chan;
        logic [STEP_BITS-1:0]  step;
    } dp_ctrl_t;

endpackage

/* design/hgcm_range.sv */
// Height range tracker: keeps the least and greatest height of the scan pass.
// Depends on hgcm_pkg.
module hgcm_range
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   update,
    input  logic                                   first,
    input  logic signed [hgcm_pkg::HEIGHT_BITS-1:0] height,
    output logic signed [hgcm_pkg::HEIGHT_BITS-1:0] min_height,
    output logic signed [hgcm_pkg::HEIGHT_BITS-1:0] max_height,
    output logic        [hgcm_pkg::HEIGHT_BITS-1:0] span
);

    logic signed [hgcm_pkg::HEIGHT_BITS-1:0] min_reg;
    logic signed [hgcm_pkg::HEIGHT_BITS-1:0] min_next;
    logic signed [hgcm_pkg::HEIGHT_BITS-1:0] max_reg;
    logic signed [hgcm_pkg::HEIGHT_BITS-1:0] max_next;
    logic signed [hgcm_pkg::HEIGHT_BITS:0]   diff;

    always_comb
    begin
        min_next = min_reg;
        max_next = max_reg;
        if (update)
        begin
            if (first)
            begin
                min_next = height;
                max_next = height;
            end
            else
            begin
                if (height > max_reg)
                begin
                    max_next = height;
                end
                if (height < min_reg)
                begin
                    min_next = height;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg <= '0;
            max_reg <= '0;
        end
        else
        begin
            min_reg <= min_next;
            max_reg <= max_next;
        end
    end

    // The greatest height never falls below the least, so the span fits unsigned.
    assign diff       = {max_reg[hgcm_pkg::HEIGHT_BITS-1], max_reg}
                      - {min_reg[hgcm_pkg::HEIGHT_BITS-1], min_reg};
    assign span       = diff[hgcm_pkg::HEIGHT_BITS-1:0];
    assign min_height = min_reg;
    assign max_height = max_reg;

endmodule

/* design/hgcm_datapath.sv */
// Shared arithmetic unit: one multiplier and one add/subtract stage, reused for
// every channel's products, the clamp test and the restoring division steps.
// Depends on hgcm_pkg.
module hgcm_datapath
(
    input  logic                                    clk,
    input  hgcm_pkg::dp_ctrl_t                      ctrl,
    input  logic signed [hgcm_pkg::HEIGHT_BITS-1:0] height,
    input  logic        [hgcm_pkg::COLOR_BITS-1:0]  own_color,
    input  logic signed [hgcm_pkg::HEIGHT_BITS-1:0] min_height,
    input  logic        [hgcm_pkg::HEIGHT_BITS-1:0] span,
    input  logic        [hgcm_pkg::COLOR_BITS-1:0]  low_color,
    input  logic        [hgcm_pkg::COLOR_BITS-1:0]  high_color,
    output logic                                    div_needed,
    output logic        [hgcm_pkg::COLOR_BITS-1:0]  pixel
);

    localparam int HB = hgcm_pkg::HEIGHT_BITS;
    localparam int CB = hgcm_pkg::CHAN_BITS;
    localparam int NB = hgcm_pkg::NUM_BITS;

    logic signed [HB:0]                    t_reg;
    logic        [HB-1:0]                  d_reg;
    logic signed [NB-1:0]                  acc_reg;
    logic signed [NB-1:0]                  prod_reg;
    logic        [CB-1:0]                  quo_reg;
    logic        [hgcm_pkg::COLOR_BITS-1:0] res_reg;

    logic        [CB-1:0]                       cl;
    logic        [CB-1:0]                       ch;
    logic signed [hgcm_pkg::MUL_A_BITS-1:0]     mul_a;
    logic signed [hgcm_pkg::MUL_B_BITS-1:0]     mul_b;
    logic signed [hgcm_pkg::PROD_BITS-1:0]      prod;
    logic signed [NB-1:0]                       prod_ext;
    logic signed [NB-1:0]                       dsh;
    logic signed [NB-1:0]                       add_b;
    logic signed [NB-1:0]                       sum;
    logic        [NB-1:0]                       sat_lim;
    logic                                       flat;
    logic                                       neg;
    logic                                       sat;
    logic        [CB-1:0]                       acc_byte;
    logic        [CB-1:0]                       div_byte;

    // Channel select
    always_comb
    begin
        case (ctrl.chan)
            hgcm_pkg::CH_RED:
            begin
                cl = low_color[3*CB-1:2*CB];
                ch = high_color[3*CB-1:2*CB];
            end
            hgcm_pkg::CH_GREEN:
            begin
                cl = low_color[2*CB-1:CB];
                ch = high_color[2*CB-1:CB];
            end
            default:
            begin
                cl = low_color[CB-1:0];
                ch = high_color[CB-1:0];
            end
        endcase
    end

    // Shared multiplier: c_lo * d, then (c_hi - c_lo) * t.
    always_comb
    begin
        if (ctrl.op == hgcm_pkg::OP_MUL_SPAN)
        begin
            mul_a = $signed({1'b0, ch}) - $signed({1'b0, cl});
            mul_b = t_reg;
        end
        else
        begin
            mul_a = $signed({1'b0, cl});
            mul_b = $signed({1'b0, d_reg});
        end
    end

    assign prod     = mul_a * mul_b;
    assign prod_ext = {{(NB - hgcm_pkg::PROD_BITS){prod[hgcm_pkg::PROD_BITS-1]}}, prod};

    // Shared adder: accumulation of the numerator, or trial subtraction of d << step.
    assign dsh     = $signed({{(NB - HB){1'b0}}, d_reg} << ctrl.step);
    assign add_b   = (ctrl.op == hgcm_pkg::OP_DIV) ? -dsh : prod_reg;
    assign sum     = acc_reg + add_b;
    assign sat_lim = {{(NB - HB){1'b0}}, d_reg} << CB;

    assign flat = (d_reg == '0);
    assign neg  = sum[NB-1];
    assign sat  = !neg && ($unsigned(sum) >= sat_lim);

    always_comb
    begin
        if (flat)
        begin
            acc_byte = cl;
        end
        else if (neg)
        begin
            acc_byte = '0;
        end
        else
        begin
            acc_byte = '1;
        end
    end

    assign div_needed = (ctrl.op == hgcm_pkg::OP_ACC) && !flat && !neg && !sat;
    assign div_byte   = {quo_reg[CB-2:0], !neg};

    always_ff @(posedge clk)
    begin
        case (ctrl.op)
            hgcm_pkg::OP_LOAD:
            begin
                t_reg <= $signed({height[HB-1], height}) - $signed({min_height[HB-1], min_height});
                d_reg <= span;
            end
            hgcm_pkg::OP_OWN:
            begin
                res_reg <= own_color;
            end
            hgcm_pkg::OP_MUL_LO:
            begin
                acc_reg <= prod_ext;
            end
            hgcm_pkg::OP_MUL_SPAN:
            begin
                prod_reg <= prod_ext;
            end
            hgcm_pkg::OP_ACC:
            begin
                acc_reg <= sum;
                if (!div_needed)
                begin
                    case (ctrl.chan)
                        hgcm_pkg::CH_RED:   res_reg[3*CB-1:2*CB] <= acc_byte;
                        hgcm_pkg::CH_GREEN: res_reg[2*CB-1:CB]   <= acc_byte;
                        default:            res_reg[CB-1:0]      <= acc_byte;
                    endcase
                end
            end
            hgcm_pkg::OP_DIV:
            begin
                if (!neg)
                begin
                    acc_reg <= sum;
                end
                quo_reg <= div_byte;
                if (ctrl.step == '0)
                begin
                    case (ctrl.chan)
                        hgcm_pkg::CH_RED:   res_reg[3*CB-1:2*CB] <= div_byte;
                        hgcm_pkg::CH_GREEN: res_reg[2*CB-1:CB]   <= div_byte;
                        default:            res_reg[CB-1:0]      <= div_byte;
                    endcase
                end
            end
            default:
            begin
                res_reg <= res_reg;
            end
        endcase
    end

    assign pixel = res_reg;

endmodule

/* design/hgcm_seq.sv */
// Sequencer for the shared arithmetic unit: walks the three channels through
// multiply, accumulate and division steps. Depends on hgcm_pkg.
module hgcm_seq
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_fire,
    input  logic               kind,
    input  logic               has_color,
    input  logic               div_needed,
    input  logic               out_free,
    output hgcm_pkg::dp_ctrl_t ctrl,
    output logic               ready,
    output logic               load_out
);

    hgcm_pkg::seq_state_t             state_reg;
    hgcm_pkg::seq_state_t             state_next;
    hgcm_pkg::chan_t                  chan_reg;
    hgcm_pkg::chan_t                  chan_next;
    logic [hgcm_pkg::STEP_BITS-1:0]   step_reg;
    logic [hgcm_pkg::STEP_BITS-1:0]   step_next;
    hgcm_pkg::chan_t                  chan_down;

    always_comb
    begin
        case (chan_reg)
            hgcm_pkg::CH_RED:   chan_down = hgcm_pkg::CH_GREEN;
            default:            chan_down = hgcm_pkg::CH_BLUE;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        chan_next  = chan_reg;
        step_next  = step_reg;
        ctrl.op    = hgcm_pkg::OP_IDLE;
        ctrl.chan  = chan_reg;
        ctrl.step  = step_reg;
        load_out   = 1'b0;

        case (state_reg)
            hgcm_pkg::S_IDLE:
            begin
                if (in_fire && (kind == hgcm_pkg::KIND_COLOR))
                begin
                    if (has_color)
                    begin
                        ctrl.op    = hgcm_pkg::OP_OWN;
                        state_next = hgcm_pkg::S_DONE;
                    end
                    else
                    begin
                        ctrl.op    = hgcm_pkg::OP_LOAD;
                        chan_next  = hgcm_pkg::CH_RED;
                        state_next = hgcm_pkg::S_MUL_LO;
                    end
                end
            end
            hgcm_pkg::S_MUL_LO:
            begin
                ctrl.op    = hgcm_pkg::OP_MUL_LO;
                state_next = hgcm_pkg::S_MUL_SPAN;
            end
            hgcm_pkg::S_MUL_SPAN:
            begin
                ctrl.op    = hgcm_pkg::OP_MUL_SPAN;
                state_next = hgcm_pkg::S_ACC;
            end
            hgcm_pkg::S_ACC:
            begin
                ctrl.op = hgcm_pkg::OP_ACC;
                if (div_needed)
                begin
                    step_next  = hgcm_pkg::STEP_BITS'(hgcm_pkg::CHAN_BITS - 1);
                    state_next = hgcm_pkg::S_DIV;
                end
                else if (chan_reg == hgcm_pkg::CH_BLUE)
                begin
                    state_next = hgcm_pkg::S_DONE;
                end
                else
                begin
                    chan_next  = chan_down;
                    state_next = hgcm_pkg::S_MUL_LO;
                end
            end
            hgcm_pkg::S_DIV:
            begin
                ctrl.op = hgcm_pkg::OP_DIV;
                if (step_reg != '0)
                begin
                    step_next = step_reg - 1'b1;
                end
                else if (chan_reg == hgcm_pkg::CH_BLUE)
                begin
                    state_next = hgcm_pkg::S_DONE;
                end
                else
                begin
                    chan_next  = chan_down;
                    state_next = hgcm_pkg::S_MUL_LO;
                end
            end
            hgcm_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    load_out   = 1'b1;
                    state_next = hgcm_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = hgcm_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= hgcm_pkg::S_IDLE;
            chan_reg  <= hgcm_pkg::CH_RED;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            chan_reg  <= chan_next;
            step_reg  <= step_next;
        end
    end

    assign ready = (state_reg == hgcm_pkg::S_IDLE);

endmodule

/* design/height_gradient_color_mapper.sv */
// Top level of the height gradient colour mapper.
// Depends on hgcm_pkg, hgcm_range, hgcm_datapath and hgcm_seq.
//
// Input items arrive on the s_ stream. tuser bit 0 is the kind (0 = scan the height
// into the running range, 1 = colour the point) and tuser bit 1 marks the first point
// of a scan pass, which restarts the range at its height. Colour items give one 24-bit
// RGB item on the m_ stream; scan items give none. low_color (index 0) and high_color
// (index 1) are written through the cfg channel, which is always ready; write them
// only while the block is idle.
//
// A scan item only updates the range. A colour item with its own colour is copied into
// the datapath, then moved into the result register. An interpolated item goes through
// one shared multiplier and one shared adder: per channel a multiply of the low colour
// by the span, a multiply of the colour difference by the offset, an accumulate-and-
// clamp step and, unless the value clamps or the range is flat, a restoring division
// with one step per channel bit. The result then moves into the result register, and the
// next item is taken only after that; s_tready is low throughout that work.
//
// rst_n clears the range to zero, the colours to black and white, and empties the result
// register. A finished result waits in the result register while m_tready is low; the
// next item is still taken, and its own result is held back inside until the register
// has been emptied.
module height_gradient_color_mapper
(
    input  logic                                      clk,
    input  logic                                      rst_n,
    // Input stream
    input  logic                                      s_tvalid,
    output logic                                      s_tready,
    // tdata from bit 0: height[15:0], has_color, own_color[23:0], zero padding
    input  logic [hgcm_pkg::IN_DATA_BITS-1:0]         s_tdata,
    // tuser from bit 0: kind, first
    input  logic [hgcm_pkg::IN_USER_BITS-1:0]         s_tuser,
    // Output stream
    output logic                                      m_tvalid,
    input  logic                                      m_tready,
    // tdata from bit 0: pixel_color[23:0]
    output logic [hgcm_pkg::OUT_DATA_BITS-1:0]        m_tdata,
    // Configuration write channel
    input  logic                                      cfg_valid,
    output logic                                      cfg_ready,
    input  logic [hgcm_pkg::CFG_INDEX_BITS-1:0]       cfg_index,
    input  logic [hgcm_pkg::COLOR_BITS-1:0]           cfg_data
);

    localparam int HB = hgcm_pkg::HEIGHT_BITS;
    localparam int CB = hgcm_pkg::COLOR_BITS;

    // Unpacked input fields
    logic                  in_kind;
    logic                  in_first;
    logic signed [HB-1:0]  in_height;
    logic                  in_has_color;
    logic [CB-1:0]         in_own_color;
    logic                  in_fire;

    assign in_kind      = s_tuser[0];
    assign in_first     = s_tuser[1];
    assign in_height    = $signed(s_tdata[HB-1:0]);
    assign in_has_color = s_tdata[HB];
    assign in_own_color = s_tdata[HB+CB:HB+1];
    assign in_fire      = s_tvalid && s_tready;

    // Configuration registers
    logic [CB-1:0] low_color_reg;
    logic [CB-1:0] high_color_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_color_reg  <= hgcm_pkg::LOW_COLOR_RESET;
            high_color_reg <= hgcm_pkg::HIGH_COLOR_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                hgcm_pkg::CFG_LOW_COLOR:  low_color_reg  <= cfg_data;
                hgcm_pkg::CFG_HIGH_COLOR: high_color_reg <= cfg_data;
                default:                  low_color_reg  <= low_color_reg;
            endcase
        end
    end

    // Height range of the scan pass
    logic signed [HB-1:0] min_height;
    logic signed [HB-1:0] max_height;
    logic        [HB-1:0] span;

    hgcm_range u_range
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .update     (in_fire && (in_kind == hgcm_pkg::KIND_SCAN)),
        .first      (in_first),
        .height     (in_height),
        .min_height (min_height),
        .max_height (max_height),
        .span       (span)
    );

    // Sequencer and shared arithmetic unit
    hgcm_pkg::dp_ctrl_t ctrl;
    logic               div_needed;
    logic               load_out;
    logic               out_free;
    logic [CB-1:0]      pixel;

    hgcm_seq u_seq
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_fire    (in_fire),
        .kind       (in_kind),
        .has_color  (in_has_color),
        .div_needed (div_needed),
        .out_free   (out_free),
        .ctrl       (ctrl),
        .ready      (s_tready),
        .load_out   (load_out)
    );

    hgcm_datapath u_datapath
    (
        .clk        (clk),
        .ctrl       (ctrl),
        .height     (in_height),
        .own_color  (in_own_color),
        .min_height (min_height),
        .span       (span),
        .low_color  (low_color_reg),
        .high_color (high_color_reg),
        .div_needed (div_needed),
        .pixel      (pixel)
    );

    // Result register, which separates the work from a stalling receiver.
    logic          out_valid_reg;
    logic          out_valid_next;
    logic [CB-1:0] out_data_reg;

    assign out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_data_reg <= pixel;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(hgcm_pkg::OUT_DATA_BITS - CB){1'b0}}, out_data_reg};

    // The range never inverts.
    a_range_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        min_height <= max_height)
        else $error("height range inverted");

    // A colour item keeps the block busy in the following cycle.
    a_colour_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && (in_kind == hgcm_pkg::KIND_COLOR)) |=> !s_tready)
        else $error("input taken while a colour item is in work");

    // A result is moved into the result register only when it is free.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |-> out_free)
        else $error("pending result overwritten");

    // Division steps only happen while the block is busy.
    a_div_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.op == hgcm_pkg::OP_DIV) |-> !s_tready)
        else $error("division step while idle");

endmodule

/* tb/sv/height_gradient_color_mapper_test.sv */
// Self-checking testbench for the height gradient colour mapper.
// Depends on hgcm_pkg and height_gradient_color_mapper; reads no files.
`timescale 1ns / 100ps

module height_gradient_color_mapper_test;

    import hgcm_pkg::*;

    // Run-length knobs. DRAIN_CYCLES is the pause after the last result, which covers a
    // scan item still in flight.
    localparam int     DRAIN_CYCLES   = 40;
    localparam int     RAND_PER_PHASE = 205;
    localparam int     NUM_PHASES     = 9;
    localparam int     HOLD_AFTER     = 400;
    localparam int     HOLD_CYCLES    = 300;
    localparam longint TIMEOUT_NS     = 64'd7_200_000;

    // One map point as it travels on the input stream.
    typedef struct {
        logic                          kind;
        logic                          first_mark;
        logic signed [HEIGHT_BITS-1:0] height;
        logic                          has_color;
        logic [COLOR_BITS-1:0]         own_color;
    } map_point_t;

    logic                      clk       = 1'b0;
    logic                      rst_n     = 1'b0;
    logic                      s_tvalid  = 1'b0;
    logic                      s_tready;
    logic [IN_DATA_BITS-1:0]   s_tdata   = '0;
    logic [IN_USER_BITS-1:0]   s_tuser   = '0;
    logic                      m_tvalid;
    logic                      m_tready  = 1'b0;
    logic [OUT_DATA_BITS-1:0]  m_tdata;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index = CFG_LOW_COLOR;
    logic [COLOR_BITS-1:0]     cfg_data  = '0;

    // Points waiting to be offered, and colours the block still owes us.
    map_point_t            point_q[$];
    logic [COLOR_BITS-1:0] pixel_q[$];

    // Our own copy of the block's registers and height range.
    logic [COLOR_BITS-1:0]         grad_lo   = LOW_COLOR_RESET;
    logic [COLOR_BITS-1:0]         grad_hi   = HIGH_COLOR_RESET;
    logic signed [HEIGHT_BITS-1:0] range_min = '0;
    logic signed [HEIGHT_BITS-1:0] range_max = '0;

    // Bookkeeping.
    map_point_t on_bus;
    int         points_queued  = 0;
    int         points_taken   = 0;
    int         scans_taken    = 0;
    int         colours_taken  = 0;
    int         pixels_checked = 0;
    int         error_count    = 0;
    int         gap_left       = 0;
    int         stall_left     = 0;
    int         hold_left      = 0;
    logic       hold_done      = 1'b0;
    logic       send_burst     = 1'b0;
    logic       recv_burst     = 1'b0;

    height_gradient_color_mapper i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    task automatic flag_error(input string msg);
        $display("ERROR at %0t ns: %s", $time, msg);
        error_count++;
    endtask

    // Idle cycles before the next item or result; zero throughout a burst stretch.
    function automatic int draw_wait(input logic burst);
        return burst ? 0 : int'($urandom_range(0, 11));
    endfunction

    // One channel of the gradient, computed exactly as
    // floor((lo * span + (hi - lo) * offs) / span) and clamped to 0..255.
    // A flat range gives the low colour.
    function automatic logic [CHAN_BITS-1:0] blend_chan(input logic [CHAN_BITS-1:0] c_lo,
                                                        input logic [CHAN_BITS-1:0] c_hi,
                                                        input longint offs,
                                                        input longint span);
        longint num;
        if (span <= 0)
            return c_lo;
        num = longint'(c_lo) * span + (longint'(c_hi) - longint'(c_lo)) * offs;
        if (num < 0)
            return '0;
        if (num >= 256 * span)
            return '1;
        return CHAN_BITS'(num / span);
    endfunction

    // Applies one accepted point to the height range, or works out its colour.
    task automatic predict_point(input map_point_t pt);
        longint                span;
        longint                offs;
        logic [COLOR_BITS-1:0] colour;
        if (pt.kind == KIND_SCAN)
        begin
            // The first mark restarts the range; otherwise the point widens it.
            if (pt.first_mark)
            begin
                range_min = pt.height;
                range_max = pt.height;
            end
            else
            begin
                if (pt.height > range_max)
                    range_max = pt.height;
                if (pt.height < range_min)
                    range_min = pt.height;
            end
        end
        else if (pt.has_color)
            pixel_q.push_back(pt.own_color);
        else
        begin
            span = longint'(range_max) - longint'(range_min);
            offs = longint'(pt.height) - longint'(range_min);
            for (int c = 0; c < 3; c++)
                colour[c*CHAN_BITS +: CHAN_BITS] = blend_chan(grad_lo[c*CHAN_BITS +: CHAN_BITS],
                                                              grad_hi[c*CHAN_BITS +: CHAN_BITS],
                                                              offs, span);
            pixel_q.push_back(colour);
        end
    endtask

    // Sender. The point on the bus is predicted at the edge where it is taken;
    // a new one is offered only after the drawn number of idle cycles.
    always @(posedge clk or negedge rst_n)
    begin : p_send
        logic [IN_DATA_BITS-1:0] data_word;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            gap_left <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                predict_point(on_bus);
                points_taken <= points_taken + 1;
                if (on_bus.kind == KIND_SCAN)
                    scans_taken <= scans_taken + 1;
                else
                    colours_taken <= colours_taken + 1;
            end
            if (s_tvalid && !s_tready)
            begin
                // Still waiting for the block to take the current item.
            end
            else if (gap_left != 0)
            begin
                s_tvalid <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (point_q.size() != 0)
            begin
                on_bus = point_q.pop_front();
                data_word = '0;
                data_word[HEIGHT_BITS-1:0] = on_bus.height;
                data_word[HEIGHT_BITS] = on_bus.has_color;
                data_word[HEIGHT_BITS+1 +: COLOR_BITS] = on_bus.own_color;
                s_tdata  <= data_word;
                s_tuser  <= {on_bus.first_mark, on_bus.kind};
                s_tvalid <= 1'b1;
                if ($urandom_range(0, 39) == 0)
                    send_burst = !send_burst;
                gap_left <= draw_wait(send_burst);
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Long receiver hold-off, counted here. It starts once a few hundred items
    // have gone in, while the sender keeps offering, so that the block's result
    // register and its internal holding stage fill and s_tready drops.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (!hold_done && points_taken >= HOLD_AFTER)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // Receiver. Each colour taken is checked against the oldest one owed.
    always @(posedge clk or negedge rst_n)
    begin : p_recv
        int wait_cycles;
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (pixel_q.size() == 0)
                    flag_error($sformatf("pixel_color %06h arrived with none expected",
                                         m_tdata[COLOR_BITS-1:0]));
                else
                begin
                    if (m_tdata[COLOR_BITS-1:0] !== pixel_q[0])
                        flag_error($sformatf("pixel_color got %06h, expected %06h",
                                             m_tdata[COLOR_BITS-1:0], pixel_q[0]));
                    void'(pixel_q.pop_front());
                end
                pixels_checked++;
            end
            if (hold_left != 0)
                m_tready <= 1'b0;
            else if (m_tvalid && m_tready)
            begin
                if ($urandom_range(0, 39) == 0)
                    recv_burst = !recv_burst;
                wait_cycles = draw_wait(recv_burst);
                if (wait_cycles != 0)
                begin
                    m_tready   <= 1'b0;
                    stall_left <= wait_cycles - 1;
                end
            end
            else if (!m_tready)
            begin
                if (stall_left == 0)
                    m_tready <= 1'b1;
                else
                    stall_left <= stall_left - 1;
            end
        end
    end

    task automatic add_point(input logic kind, input logic first_mark,
                             input logic signed [HEIGHT_BITS-1:0] height,
                             input logic has_color, input logic [COLOR_BITS-1:0] own_color);
        map_point_t pt;
        pt.kind       = kind;
        pt.first_mark = first_mark;
        pt.height     = height;
        pt.has_color  = has_color;
        pt.own_color  = own_color;
        point_q.push_back(pt);
        points_queued++;
    endtask

    // A height near the centre, clipped to the signed 16-bit range.
    function automatic logic signed [HEIGHT_BITS-1:0] near_height(input longint centre,
                                                                  input longint spread);
        longint v;
        v = centre + longint'($urandom_range(0, 32'(2 * spread))) - spread;
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return v[HEIGHT_BITS-1:0];
    endfunction

    // Mostly a well-formed scan pass followed by a colour pass with random
    // content; now and then a scan pass without its first mark, or a lone
    // point with every field random.
    task automatic add_random_run();
        int     pick;
        int     n_scan;
        int     n_col;
        longint centre;
        longint spread;
        logic signed [HEIGHT_BITS-1:0] h;
        pick = $urandom_range(0, 9);
        if (pick == 0)
        begin
            add_point(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      HEIGHT_BITS'($urandom()), 1'($urandom_range(0, 1)),
                      COLOR_BITS'($urandom()));
            return;
        end
        case ($urandom_range(0, 3))
            0:       centre = $urandom_range(0, 1) ? 32767 : -32768;
            1:       centre = longint'($urandom_range(0, 40)) - 20;
            default: centre = longint'($urandom_range(0, 65535)) - 32768;
        endcase
        // Narrow ranges stress the rounding, wide ones the multiplier width.
        case ($urandom_range(0, 6))
            0:       spread = 0;
            1:       spread = 1;
            2:       spread = 2;
            3:       spread = 7;
            4:       spread = 300;
            5:       spread = 9000;
            default: spread = 65535;
        endcase
        n_scan = $urandom_range(1, 6);
        for (int i = 0; i < n_scan; i++)
            add_point(KIND_SCAN, (i == 0) && (pick != 1), near_height(centre, spread),
                      1'($urandom_range(0, 1)), COLOR_BITS'($urandom()));
        n_col = $urandom_range(1, 10);
        for (int i = 0; i < n_col; i++)
        begin
            // A slightly wider window reaches heights outside the scanned range.
            if ($urandom_range(0, 7) == 0)
                h = HEIGHT_BITS'($urandom());
            else
                h = near_height(centre, spread + spread / 4 + 2);
            add_point(KIND_COLOR, $urandom_range(0, 15) == 0, h,
                      $urandom_range(0, 3) == 0, COLOR_BITS'($urandom()));
        end
    endtask

    // Writes both colour registers back to back, keeping valid high between.
    task automatic write_colors(input logic [COLOR_BITS-1:0] lo,
                                input logic [COLOR_BITS-1:0] hi);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_LOW_COLOR;
        cfg_data  <= lo;
        do @(posedge clk); while (!cfg_ready);
        grad_lo = lo;
        cfg_index <= CFG_HIGH_COLOR;
        cfg_data  <= hi;
        do @(posedge clk); while (!cfg_ready);
        grad_hi = hi;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Waits until every queued point has been taken and every colour checked,
    // then lets a scan item that may still be in the block finish.
    task automatic wait_drained();
        do @(posedge clk); while (points_taken != points_queued || pixel_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        logic [COLOR_BITS-1:0] lo;
        logic [COLOR_BITS-1:0] hi;
        int                    target;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            // The first settings are the extremes: the reset gradient, its
            // reverse, equal colours, and opposing channel directions.
            case (phase)
                0:       begin lo = 24'h000000; hi = 24'hFFFFFF; end
                1:       begin lo = 24'hFFFFFF; hi = 24'h000000; end
                2:       begin lo = 24'h123456; hi = 24'h123456; end
                3:       begin lo = 24'h000000; hi = 24'h000000; end
                4:       begin lo = 24'hFFFFFF; hi = 24'hFFFFFF; end
                5:       begin lo = 24'h00FF00; hi = 24'hFF00FF; end
                default: begin lo = COLOR_BITS'($urandom()); hi = COLOR_BITS'($urandom()); end
            endcase
            write_colors(lo, hi);

            if (phase == 0)
            begin
                // Colour right after reset: the range is still flat at zero.
                add_point(KIND_COLOR, 1'b0, 16'sd0, 1'b0, 24'h000000);
                // Scan points without a first mark widen the reset range.
                add_point(KIND_SCAN, 1'b0, 16'sd100, 1'b0, 24'hFFFFFF);
                add_point(KIND_SCAN, 1'b0, -16'sd32768, 1'b1, 24'h000000);
                add_point(KIND_SCAN, 1'b0, 16'sd32767, 1'b0, 24'h5A5A5A);
                // Interpolation across the widest range, ends included.
                add_point(KIND_COLOR, 1'b0, -16'sd32768, 1'b0, 24'hFFFFFF);
                add_point(KIND_COLOR, 1'b0, 16'sd32767, 1'b0, 24'h000000);
                add_point(KIND_COLOR, 1'b0, 16'sd0, 1'b0, 24'hA5A5A5);
                add_point(KIND_COLOR, 1'b0, 16'sd12345, 1'b0, 24'h5A5A5A);
                add_point(KIND_COLOR, 1'b0, -16'sd1, 1'b0, 24'h000000);
                // Own colours pass straight through.
                add_point(KIND_COLOR, 1'b0, 16'sd5, 1'b1, 24'hFFFFFF);
                add_point(KIND_COLOR, 1'b0, 16'sd5, 1'b1, 24'h000000);
                add_point(KIND_COLOR, 1'b1, -16'sd7, 1'b1, 24'hA5A5A5);
                // A first mark on a colour point has no effect.
                add_point(KIND_COLOR, 1'b1, 16'sd100, 1'b0, 24'h000000);
                // Flat range: every height, inside or not, gets the low colour.
                add_point(KIND_SCAN, 1'b1, 16'sd50, 1'b0, 24'h000000);
                add_point(KIND_SCAN, 1'b0, 16'sd50, 1'b0, 24'h000000);
                add_point(KIND_COLOR, 1'b0, 16'sd50, 1'b0, 24'h000000);
                add_point(KIND_COLOR, 1'b0, 16'sd70, 1'b0, 24'h000000);
                add_point(KIND_COLOR, 1'b0, -16'sd32768, 1'b0, 24'h000000);
                // Narrow range with heights beyond both ends, which clamp.
                add_point(KIND_SCAN, 1'b1, -16'sd10, 1'b0, 24'h000000);
                add_point(KIND_SCAN, 1'b0, 16'sd10, 1'b0, 24'h000000);
                add_point(KIND_COLOR, 1'b0, 16'sd30, 1'b0, 24'h000000);
                add_point(KIND_COLOR, 1'b0, -16'sd30, 1'b0, 24'h000000);
                add_point(KIND_COLOR, 1'b0, 16'sd0, 1'b0, 24'h000000);
                add_point(KIND_COLOR, 1'b0, 16'sd10, 1'b0, 24'h000000);
                add_point(KIND_COLOR, 1'b0, -16'sd10, 1'b0, 24'h000000);
            end

            target = points_queued + RAND_PER_PHASE;
            while (points_queued < target)
                add_random_run();
            wait_drained();
        end

        if (pixel_q.size() != 0)
            flag_error($sformatf("%0d colours never arrived", pixel_q.size()));

        $display("Covered %0d items (%0d scan, %0d colour) over %0d colour settings,",
                 points_taken, scans_taken, colours_taken, NUM_PHASES);
        $display("with %0d colours checked against the gradient prediction.", pixels_checked);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Watchdog: several times the slowest legal run.
    initial
    begin
        #(TIMEOUT_NS);
        $display("Timeout with %0d of %0d items taken and %0d colours owed.",
                 points_taken, points_queued, pixel_q.size());
        $display("DONE: errors detected");
        $finish;
    end

endmodule
